// ----- hw/rtl/smss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smss_pkg;

   // request kinds, carried on req_tuser
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam int KEY_W  = 32;
   localparam int IDX_W  = 2;
   localparam int REQ_TDATA_W = 72;   // 68 bits of fields, padded to bytes
   localparam int RSP_TDATA_W = 8;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } smss_state_type;

   // controller -> datapath
   typedef struct packed {
      logic wr_en;     // store the request's entry
      logic start;     // latch key, aim at top-right corner, read it
      logic step;      // move one column left or one row down, read next
      logic load_rsp;  // capture the hit flag into the output register
   } smss_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;      // walk ends at the current entry
      logic hit;       // current entry equals the key
   } smss_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/smss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smss_ctrl
   import smss_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_func,
   input  wire logic          rsp_ready,
   input  wire smss_stat_type stat,
   output logic               req_ready,
   output logic               rsp_valid,
   output smss_cmd_type       cmd
);

   smss_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_WALK;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (stat.done) begin
               // hold the last entry until the output register frees up
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/smss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smss_dp
   import smss_pkg::*;
#(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  wire logic                    clock,
   input  wire smss_cmd_type            cmd,
   input  wire logic [IDX_W-1:0]        wr_row,
   input  wire logic [IDX_W-1:0]        wr_col,
   input  wire logic signed [KEY_W-1:0] wr_value,
   input  wire logic signed [KEY_W-1:0] key,
   output smss_stat_type                stat,
   output logic                         found
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

   logic signed [KEY_W-1:0] mem [DEPTH];

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] rdata_ff;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [CW-1:0]           col_ff, col_in;
   logic                    found_ff;
   logic                    rd_en;
   logic                    wr_ok;
   logic [AW-1:0]           wr_addr;
   logic                    eq, gt;

   // out-of-range writes are dropped
   assign wr_ok   = (32'(wr_row) < ROWS) && (32'(wr_col) < COLS);
   assign wr_addr = AW'(32'(wr_row) * COLS + 32'(wr_col));

   assign eq = (rdata_ff == key_ff);
   assign gt = (rdata_ff > key_ff);

   assign stat.hit  = eq;
   assign stat.done = eq
                   || (gt  && (col_ff == '0))
                   || (!gt && (row_ff == RW'(ROWS - 1)));

   assign rd_en = cmd.start || cmd.step;

   always_comb begin
      addr_in = addr_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.start) begin
         addr_in = AW'(COLS - 1);
         row_in  = '0;
         col_in  = CW'(COLS - 1);
      end else if (cmd.step) begin
         if (gt) begin
            addr_in = addr_ff - AW'(1);
            col_in  = col_ff - CW'(1);
         end else begin
            addr_in = addr_ff + AW'(COLS);
            row_in  = row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      if (cmd.start) begin
         key_ff <= key;
      end
      if (cmd.load_rsp) begin
         found_ff <= eq;
      end
   end

   assign found = found_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_matrix_staircase_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Staircase search over a ROWS x COLS matrix whose rows and columns are sorted ascending.
// Request channel (req_*): req_tuser selects the kind of beat. A write beat stores
//   entry_value at (row_index, col_index) and returns nothing; indexes beyond the matrix
//   are dropped. A search beat walks from the top-right corner: on equal it stops with
//   found=1, on a larger entry it moves one column left, otherwise one row down, and it
//   stops with found=0 when it would leave the matrix.
// Response channel (rsp_*): one beat per search, found in rsp_tdata bit 0.
// Request side: writes are taken one per cycle, back to back, while no search is
//   walking. A search visiting k entries (1 <= k <= ROWS+COLS-1) holds the request side
//   until its result is loaded; each comparison is against the registered read port of
//   the entry memory, after the first read. The response beat appears the cycle after
//   the result is loaded.
// Stalls: the output register lets the next request in while a response waits; a search
//   that finishes while the previous response is still held waits on its last entry.
// Reset: clears the controller and the response valid. The matrix is not cleared;
//   searches must only touch entries that were written.
module sorted_matrix_staircase_search
   import smss_pkg::*;
#(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [1:0] row_index, [3:2] col_index, [35:4] entry_value, [67:36] search_key, rest zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] func
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] found, rest zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   smss_cmd_type  cmd;
   smss_stat_type stat;
   logic          found;

   smss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .cmd       (cmd)
   );

   smss_dp #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .wr_row   (req_tdata[1:0]),
      .wr_col   (req_tdata[3:2]),
      .wr_value (req_tdata[35:4]),
      .key      (req_tdata[67:36]),
      .stat     (stat),
      .found    (found)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-1){1'b0}}, found};

   // a search start locks out further requests for the walk
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready)
      else $error("request side open during a walk");

   // loading a result always presents a response beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("result loaded without response valid");

   // a walk step and a result load never coincide with a new request
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.load_rsp) |-> !(cmd.start || cmd.wr_en))
      else $error("walk overlaps a new request");

   // result is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
